// File: hw/rtl/smcs_pkg.sv
// Shared constants, types and codes for the sparse matrix coordinate store.
`timescale 1ns / 1ps
package smcs_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int INDEX_BITS = 12;
   localparam int SLOT_BITS = $clog2(MAX_ENTRIES);
   localparam int COUNT_BITS = SLOT_BITS + 1;
   localparam int VALUE_BITS = 32;
   localparam int SIZE_BITS = 13;
   localparam int STATUS_BITS = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(4096);

   localparam logic OP_READ = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_ROW = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_COLUMN = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMN_COUNT = 2'd1;

   typedef struct packed {
      logic [INDEX_BITS-1:0] row;
      logic [INDEX_BITS-1:0] column;
      logic signed [VALUE_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      entry_type wr_entry;
      logic [SLOT_BITS-1:0] rd_addr;
   } table_cmd_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] row_count;
      logic [SIZE_BITS-1:0] column_count;
   } limits_type;

endpackage

// File: hw/rtl/smcs_if.sv
// Request, response and register write channels of the coordinate store.
`timescale 1ns / 1ps
interface smcs_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [smcs_pkg::INDEX_BITS-1:0] row_index;
   logic [smcs_pkg::INDEX_BITS-1:0] column_index;
   logic signed [smcs_pkg::VALUE_BITS-1:0] write_value;
   modport source (output valid, operation, row_index, column_index, write_value,
                   input ready);
   modport sink (input valid, operation, row_index, column_index, write_value,
                 output ready);
endinterface

interface smcs_rsp_if;
   logic valid;
   logic ready;
   logic signed [smcs_pkg::VALUE_BITS-1:0] read_value;
   logic [smcs_pkg::STATUS_BITS-1:0] status;
   modport source (output valid, read_value, status, input ready);
   modport sink (input valid, read_value, status, output ready);
endinterface

interface smcs_csr_if;
   logic valid;
   logic ready;
   logic [smcs_pkg::CSR_INDEX_BITS-1:0] index;
   logic [smcs_pkg::CSR_DATA_BITS-1:0] write_data;
   modport source (output valid, index, write_data, input ready);
   modport sink (input valid, index, write_data, output ready);
endinterface

// File: hw/rtl/sparse_matrix_coordinate_store_unit.sv
// Top level of the sparse matrix coordinate store.
// Holds a sparse matrix as a table of (row, column, value) entries sorted by
// row then column. Requests arrive on req_ch (read or write of one element),
// one response per request leaves on rsp_ch with the element or old value
// and a status. csr_ch writes the row and column limits; it is always ready.
// A request is taken only while the sequencer is idle. It then scans the
// table one entry a cycle through the single registered read port, and a
// write that inserts moves later entries up one slot a cycle. A range error
// goes straight to the response; a read or overwrite scans up to the first
// entry whose key is not below the request, a miss scans past all entries
// held, an append then places the entry at the end, and an insert in front
// of held entries shifts the later entries up before placing it. The next
// request is taken once the response is loaded and the sequencer is idle.
// The response waits in an output register; a new request may be taken
// while it is held, but the next response is not loaded until it is taken.
// Synchronous reset empties the table (entry count zero, no clearing pass)
// and sets both limits to 4096.
`timescale 1ns / 1ps
module sparse_matrix_coordinate_store_unit (
   input  logic        clock,
   input  logic        reset,
   smcs_req_if.sink    req_ch,
   smcs_rsp_if.source  rsp_ch,
   smcs_csr_if.sink    csr_ch
);

   smcs_pkg::limits_type limits_ff, limits_in;
   smcs_pkg::table_cmd_type cmd;
   smcs_pkg::entry_type rd_entry;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      limits_in = limits_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            smcs_pkg::CSR_ROW_COUNT: begin
               limits_in.row_count = csr_ch.write_data[smcs_pkg::SIZE_BITS-1:0];
            end
            smcs_pkg::CSR_COLUMN_COUNT: begin
               limits_in.column_count = csr_ch.write_data[smcs_pkg::SIZE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.row_count <= smcs_pkg::SIZE_RESET;
         limits_ff.column_count <= smcs_pkg::SIZE_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   smcs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .limits   (limits_ff),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .cmd      (cmd),
      .rd_entry (rd_entry)
   );

   smcs_table u_table (
      .clock    (clock),
      .cmd      (cmd),
      .rd_entry (rd_entry)
   );

endmodule

// File: hw/rtl/smcs_table.sv
// Entry table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module smcs_table (
   input  logic                    clock,
   input  smcs_pkg::table_cmd_type cmd,
   output smcs_pkg::entry_type     rd_entry
);

   smcs_pkg::entry_type mem [smcs_pkg::MAX_ENTRIES];
   smcs_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_entry;
      end
      rd_entry_ff <= mem[cmd.rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// File: hw/rtl/smcs_seq.sv
// Sequencer: key scan, insertion shift and response register.
`timescale 1ns / 1ps
module smcs_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  smcs_pkg::limits_type    limits,
   smcs_req_if.sink                req,
   smcs_rsp_if.source              rsp,
   output smcs_pkg::table_cmd_type cmd,
   input  smcs_pkg::entry_type     rd_entry
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_PRIME = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_PLACE = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   localparam logic [smcs_pkg::COUNT_BITS-1:0] COUNT_FULL =
      smcs_pkg::COUNT_BITS'(smcs_pkg::MAX_ENTRIES);

   logic [2:0] state_ff, state_in;
   logic [smcs_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [smcs_pkg::COUNT_BITS-1:0] idx_ff, idx_in;
   logic [smcs_pkg::COUNT_BITS-1:0] slot_ff, slot_in;
   logic [smcs_pkg::COUNT_BITS-1:0] ptr_ff, ptr_in;
   logic hit_ff, hit_in;
   logic op_ff, op_in;
   logic [smcs_pkg::INDEX_BITS-1:0] row_ff, row_in;
   logic [smcs_pkg::INDEX_BITS-1:0] column_ff, column_in;
   logic signed [smcs_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic signed [smcs_pkg::VALUE_BITS-1:0] result_ff, result_in;
   logic [smcs_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [smcs_pkg::VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [smcs_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic rsp_load;

   logic [smcs_pkg::COUNT_BITS-1:0] idx_plus;
   logic [smcs_pkg::COUNT_BITS-1:0] ptr_minus;
   logic [smcs_pkg::COUNT_BITS-1:0] ptr_minus2;
   logic [2*smcs_pkg::INDEX_BITS-1:0] key_stored;
   logic [2*smcs_pkg::INDEX_BITS-1:0] key_wanted;
   logic key_ge, key_eq;

   assign idx_plus = idx_ff + smcs_pkg::COUNT_BITS'(1);
   assign ptr_minus = ptr_ff - smcs_pkg::COUNT_BITS'(1);
   assign ptr_minus2 = ptr_ff - smcs_pkg::COUNT_BITS'(2);

   // shared key comparator
   assign key_stored = {rd_entry.row, rd_entry.column};
   assign key_wanted = {row_ff, column_ff};
   assign key_ge = key_stored >= key_wanted;
   assign key_eq = key_stored == key_wanted;

   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      slot_in = slot_ff;
      ptr_in = ptr_ff;
      hit_in = hit_ff;
      op_in = op_ff;
      row_in = row_ff;
      column_in = column_ff;
      value_in = value_ff;
      result_in = result_ff;
      status_in = status_ff;
      rsp_load = 1'b0;
      cmd.wr_en = 1'b0;
      cmd.wr_addr = slot_ff[smcs_pkg::SLOT_BITS-1:0];
      cmd.wr_entry.row = row_ff;
      cmd.wr_entry.column = column_ff;
      cmd.wr_entry.value = value_ff;
      cmd.rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in = req.operation;
               row_in = req.row_index;
               column_in = req.column_index;
               value_in = req.write_value;
               idx_in = '0;
               slot_in = '0;
               hit_in = 1'b0;
               result_in = '0;
               status_in = smcs_pkg::STATUS_OK;
               if ({1'b0, req.row_index} >= limits.row_count) begin
                  status_in = smcs_pkg::STATUS_BAD_ROW;
                  state_in = ST_FINISH;
               end else if ({1'b0, req.column_index} >= limits.column_count) begin
                  status_in = smcs_pkg::STATUS_BAD_COLUMN;
                  state_in = ST_FINISH;
               end else if (count_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_addr = idx_plus[smcs_pkg::SLOT_BITS-1:0];
            if (key_ge) begin
               slot_in = idx_ff;
               hit_in = key_eq;
               result_in = key_eq ? rd_entry.value : '0;
               state_in = ST_DECIDE;
            end else if (idx_plus == count_ff) begin
               slot_in = idx_plus;
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_plus;
            end
         end
         ST_DECIDE: begin
            if (hit_ff) begin
               cmd.wr_en = (op_ff == smcs_pkg::OP_WRITE);
               state_in = ST_FINISH;
            end else if (op_ff == smcs_pkg::OP_READ) begin
               state_in = ST_FINISH;
            end else if (count_ff == COUNT_FULL) begin
               status_in = smcs_pkg::STATUS_FULL;
               state_in = ST_FINISH;
            end else if (slot_ff == count_ff) begin
               state_in = ST_PLACE;
            end else begin
               ptr_in = count_ff;
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.rd_addr = ptr_minus[smcs_pkg::SLOT_BITS-1:0];
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = ptr_ff[smcs_pkg::SLOT_BITS-1:0];
            cmd.wr_entry = rd_entry;
            cmd.rd_addr = ptr_minus2[smcs_pkg::SLOT_BITS-1:0];
            if (ptr_minus == slot_ff) begin
               state_in = ST_PLACE;
            end else begin
               ptr_in = ptr_minus;
            end
         end
         ST_PLACE: begin
            cmd.wr_en = 1'b1;
            count_in = count_ff + smcs_pkg::COUNT_BITS'(1);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);
   assign rsp_value_in = rsp_load ? result_ff : rsp_value_ff;
   assign rsp_status_in = rsp_load ? status_ff : rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      slot_ff <= slot_in;
      ptr_ff <= ptr_in;
      hit_ff <= hit_in;
      op_ff <= op_in;
      row_ff <= row_in;
      column_ff <= column_in;
      value_ff <= value_in;
      result_ff <= result_in;
      status_ff <= status_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.read_value = rsp_value_ff;
   assign rsp.status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         count_ff == $past(count_ff) + smcs_pkg::COUNT_BITS'(1))
      else $error("entry count moved by other than one");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FINISH) |-> !cmd.wr_en)
      else $error("table written outside an access");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_ff == smcs_pkg::STATUS_FULL) |-> count_ff == COUNT_FULL)
      else $error("full status with room in table");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (ptr_ff > slot_ff && ptr_ff < COUNT_FULL))
      else $error("shift pointer outside insertion range");

endmodule
